>>> sv/oale_pkg.sv
package oale_pkg;

	localparam int CMD_W     = 2;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 7;
	localparam int S_FIELD_W = POS_W + VAL_W;
	localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_FIELD_W = VAL_W + POS_W + CNT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_LOCATE = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_GET,
		ST_SHF_RD,
		ST_SHF_WR,
		ST_LOC_RD,
		ST_LOC_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_K_M1,
		RD_K_P1,
		RD_K
	} rd_sel_t;

	typedef enum logic {
		WR_SHIFT,
		WR_VALUE
	} wr_sel_t;

	typedef enum logic [2:0] {
		K_HOLD,
		K_LEN,
		K_POS,
		K_ZERO,
		K_DEC,
		K_INC
	} k_op_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		k_op_t   k_op;
		logic    len_inc;
		logic    len_dec;
		logic    set_ok;
		logic    take_removed;
		logic    set_found;
		logic    out_load;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic ins_ok;
		logic del_ok;
		logic ins_more;
		logic shf_more;
		logic loc_more;
		logic match;
		logic out_free;
	} stat_t;

endpackage

>>> sv/ordered_array_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a single-port-write,
// single-port-read memory with registered read data; one command word in gives one
// result word out. Every move of an entry is a read, then a write; an insert at
// position p moves count-p+1 entries and a delete count-p. Refused commands and the
// unused command code go from the check state straight to the done state. The next
// command word is taken while the previous result word still waits on m_tready.
module ordered_array_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [oale_pkg::S_TDATA_W-1:0] s_tdata,  // position[6:0], value[38:7]
	input  logic [oale_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [oale_pkg::M_TDATA_W-1:0] m_tdata,  // removed_value[31:0],
	                                                 // found_position[38:32], count[45:39]
	output logic [0:0]                     m_tuser   // ok[0]
);

	oale_pkg::ctrl_t ctrl;
	oale_pkg::stat_t stat;

	oale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	oale_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.ctrl     (ctrl),
		.stat     (stat)
	);

endmodule

>>> sv/oale_ctrl.sv
module oale_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  oale_pkg::stat_t  stat,
	output oale_pkg::ctrl_t  ctrl
);

	oale_pkg::state_t state_q;
	oale_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oale_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oale_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = oale_pkg::ST_CHECK;
			end
			oale_pkg::ST_CHECK: begin
				case (stat.cmd)
					oale_pkg::CMD_INSERT:
						state_d = stat.ins_ok ? oale_pkg::ST_INS_RD : oale_pkg::ST_DONE;
					oale_pkg::CMD_DELETE:
						state_d = stat.del_ok ? oale_pkg::ST_DEL_GET : oale_pkg::ST_DONE;
					oale_pkg::CMD_LOCATE:
						state_d = oale_pkg::ST_LOC_RD;
					default:
						state_d = oale_pkg::ST_DONE;
				endcase
			end
			oale_pkg::ST_INS_RD: begin
				state_d = stat.ins_more ? oale_pkg::ST_INS_WR : oale_pkg::ST_INS_PUT;
			end
			oale_pkg::ST_INS_WR: begin
				state_d = oale_pkg::ST_INS_RD;
			end
			oale_pkg::ST_INS_PUT: begin
				state_d = oale_pkg::ST_DONE;
			end
			oale_pkg::ST_DEL_GET: begin
				state_d = oale_pkg::ST_SHF_RD;
			end
			oale_pkg::ST_SHF_RD: begin
				state_d = stat.shf_more ? oale_pkg::ST_SHF_WR : oale_pkg::ST_DONE;
			end
			oale_pkg::ST_SHF_WR: begin
				state_d = oale_pkg::ST_SHF_RD;
			end
			oale_pkg::ST_LOC_RD: begin
				state_d = stat.loc_more ? oale_pkg::ST_LOC_CMP : oale_pkg::ST_DONE;
			end
			oale_pkg::ST_LOC_CMP: begin
				state_d = stat.match ? oale_pkg::ST_DONE : oale_pkg::ST_LOC_RD;
			end
			oale_pkg::ST_DONE: begin
				if (stat.out_free) state_d = oale_pkg::ST_IDLE;
			end
			default: begin
				state_d = oale_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl     = '0;
		s_tready = 1'b0;
		unique case (state_q)
			oale_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				ctrl.load = s_tvalid;
			end
			oale_pkg::ST_CHECK: begin
				ctrl.rd_en  = 1'b1;
				ctrl.rd_sel = oale_pkg::RD_POS;
				case (stat.cmd)
					oale_pkg::CMD_INSERT: if (stat.ins_ok) ctrl.k_op = oale_pkg::K_LEN;
					oale_pkg::CMD_DELETE: if (stat.del_ok) ctrl.k_op = oale_pkg::K_POS;
					oale_pkg::CMD_LOCATE: ctrl.k_op = oale_pkg::K_ZERO;
					default: ctrl.k_op = oale_pkg::K_HOLD;
				endcase
			end
			oale_pkg::ST_INS_RD: begin
				ctrl.rd_en  = stat.ins_more;
				ctrl.rd_sel = oale_pkg::RD_K_M1;
			end
			oale_pkg::ST_INS_WR: begin
				ctrl.wr_en  = 1'b1;
				ctrl.wr_sel = oale_pkg::WR_SHIFT;
				ctrl.k_op   = oale_pkg::K_DEC;
			end
			oale_pkg::ST_INS_PUT: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_sel  = oale_pkg::WR_VALUE;
				ctrl.len_inc = 1'b1;
				ctrl.set_ok  = 1'b1;
			end
			oale_pkg::ST_DEL_GET: begin
				ctrl.take_removed = 1'b1;
				ctrl.set_ok       = 1'b1;
			end
			oale_pkg::ST_SHF_RD: begin
				ctrl.rd_en   = stat.shf_more;
				ctrl.rd_sel  = oale_pkg::RD_K_P1;
				ctrl.len_dec = !stat.shf_more;
			end
			oale_pkg::ST_SHF_WR: begin
				ctrl.wr_en  = 1'b1;
				ctrl.wr_sel = oale_pkg::WR_SHIFT;
				ctrl.k_op   = oale_pkg::K_INC;
			end
			oale_pkg::ST_LOC_RD: begin
				ctrl.rd_en  = stat.loc_more;
				ctrl.rd_sel = oale_pkg::RD_K;
			end
			oale_pkg::ST_LOC_CMP: begin
				ctrl.set_found = stat.match;
				ctrl.set_ok    = stat.match;
				ctrl.k_op      = stat.match ? oale_pkg::K_HOLD : oale_pkg::K_INC;
			end
			oale_pkg::ST_DONE: begin
				ctrl.out_load = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

>>> sv/oale_datapath.sv
module oale_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [oale_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [oale_pkg::CMD_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [oale_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [0:0]                         m_tuser,
	input  oale_pkg::ctrl_t                    ctrl,
	output oale_pkg::stat_t                    stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

	oale_pkg::cmd_t                   cmd_q;
	logic [oale_pkg::POS_W-1:0]       pos_q;
	logic [oale_pkg::VAL_W-1:0]       val_q;
	logic [oale_pkg::VAL_W-1:0]       entries_q [CAPACITY];
	logic [oale_pkg::VAL_W-1:0]       rd_q;
	logic [CW-1:0]                    len_q;
	logic [CW-1:0]                    k_q;
	logic [CW-1:0]                    k_d;
	logic                             ok_q;
	logic [oale_pkg::VAL_W-1:0]       removed_q;
	logic [oale_pkg::POS_W-1:0]       found_q;
	logic                             m_tvalid_q;
	logic                             m_ok_q;
	logic [oale_pkg::VAL_W-1:0]       m_removed_q;
	logic [oale_pkg::POS_W-1:0]       m_found_q;
	logic [oale_pkg::CNT_W-1:0]       m_count_q;
	logic [AW-1:0]                    raddr;
	logic [AW-1:0]                    waddr;
	logic [oale_pkg::VAL_W-1:0]       wdata;
	logic [XW-1:0]                    pos_x;
	logic [XW-1:0]                    len_x;
	logic [XW-1:0]                    k_x;

	always_comb begin
		unique case (ctrl.rd_sel)
			oale_pkg::RD_POS:  raddr = AW'(pos_q - oale_pkg::POS_W'(1));
			oale_pkg::RD_K_M1: raddr = AW'(k_q - CW'(1));
			oale_pkg::RD_K_P1: raddr = AW'(k_q + CW'(1));
			oale_pkg::RD_K:    raddr = AW'(k_q);
			default:           raddr = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.wr_sel)
			oale_pkg::WR_SHIFT: begin
				waddr = AW'(k_q);
				wdata = rd_q;
			end
			oale_pkg::WR_VALUE: begin
				waddr = AW'(pos_q - oale_pkg::POS_W'(1));
				wdata = val_q;
			end
			default: begin
				waddr = '0;
				wdata = '0;
			end
		endcase
	end

	always_comb begin
		unique case (ctrl.k_op)
			oale_pkg::K_HOLD: k_d = k_q;
			oale_pkg::K_LEN:  k_d = len_q;
			oale_pkg::K_POS:  k_d = CW'(pos_q - oale_pkg::POS_W'(1));
			oale_pkg::K_ZERO: k_d = '0;
			oale_pkg::K_DEC:  k_d = k_q - CW'(1);
			oale_pkg::K_INC:  k_d = k_q + CW'(1);
			default:          k_d = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			entries_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= entries_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (ctrl.load) begin
			cmd_q     <= oale_pkg::cmd_t'(s_tuser);
			pos_q     <= s_tdata[oale_pkg::POS_W-1:0];
			val_q     <= s_tdata[oale_pkg::POS_W +: oale_pkg::VAL_W];
			ok_q      <= 1'b0;
			removed_q <= '0;
			found_q   <= '0;
		end else begin
			if (ctrl.set_ok) ok_q <= 1'b1;
			if (ctrl.take_removed) removed_q <= rd_q;
			if (ctrl.set_found) found_q <= oale_pkg::POS_W'(k_q + CW'(1));
		end
		if (ctrl.out_load) begin
			m_ok_q      <= ok_q;
			m_removed_q <= removed_q;
			m_found_q   <= found_q;
			m_count_q   <= oale_pkg::CNT_W'(len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.len_inc) begin
				len_q <= len_q + CW'(1);
			end else if (ctrl.len_dec) begin
				len_q <= len_q - CW'(1);
			end
			if (ctrl.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign pos_x = XW'(pos_q);
	assign len_x = XW'(len_q);
	assign k_x   = XW'(k_q);

	always_comb begin
		stat.cmd      = cmd_q;
		stat.ins_ok   = (pos_q != '0) && (pos_x <= len_x + XW'(1))
			&& (len_x < XW'(CAPACITY));
		stat.del_ok   = (pos_q != '0) && (pos_x <= len_x);
		stat.ins_more = k_x >= pos_x;
		stat.shf_more = (k_x + XW'(1)) < len_x;
		stat.loc_more = k_q < len_q;
		stat.match    = rd_q == val_q;
		stat.out_free = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {{oale_pkg::M_PAD_W{1'b0}}, m_count_q, m_found_q, m_removed_q};

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(len_q) <= XW'(CAPACITY))
		else $error("list length above capacity");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.len_inc || ctrl.len_dec) |=> (len_q != $past(len_q)))
		else $error("list length did not move");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> (XW'(waddr) < XW'(CAPACITY)))
		else $error("write beyond list storage");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result word overwritten before it was taken");

	a_len_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.len_inc && ctrl.len_dec))
		else $error("list length grows and shrinks at once");

endmodule

>>> bench/ordered_array_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_array_list_engine_tb;

	localparam int CAPACITY = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [oale_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [oale_pkg::CMD_W-1:0] cmd;
		logic [oale_pkg::POS_W-1:0] position;
		logic [oale_pkg::VAL_W-1:0] value;
		bit                         hold;
	} list_cmd_t;

	typedef struct {
		logic                       ok;
		logic [oale_pkg::VAL_W-1:0] removed;
		logic [oale_pkg::POS_W-1:0] found;
		logic [oale_pkg::CNT_W-1:0] count;
	} list_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [oale_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [oale_pkg::CMD_W-1:0]     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [oale_pkg::M_TDATA_W-1:0] m_tdata;
	logic [0:0]                     m_tuser;

	list_cmd_t    cmd_queue[$];
	list_result_t expected_results[$];
	logic [oale_pkg::VAL_W-1:0] value_pool[$];

	logic [oale_pkg::VAL_W-1:0] list_mem[CAPACITY];
	int list_len = 0;
	int plan_len = 0;
	int queued_items = 0;
	int mismatch_count = 0;

	list_cmd_t    next_cmd;
	list_result_t got_word;
	list_result_t want_word;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_run = 0;
	int idle_cycles = 0;

	ordered_array_list_engine #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // position[6:0], value[38:7]
		.s_tuser (s_tuser),   // cmd[1:0]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // removed_value[31:0], found_position[38:32], count[45:39]
		.m_tuser (m_tuser)    // ok[0]
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic list_result_t apply_to_list(logic [oale_pkg::CMD_W-1:0] c,
			logic [oale_pkg::POS_W-1:0] p, logic [oale_pkg::VAL_W-1:0] v);
		list_result_t r;
		int pos;
		int k;
		r.ok = 1'b0;
		r.removed = '0;
		r.found = '0;
		pos = int'(p);
		case (c)
			oale_pkg::CMD_INSERT: begin
				if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
					for (k = list_len; k >= pos; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[pos-1] = v;
					list_len++;
					r.ok = 1'b1;
				end
			end
			oale_pkg::CMD_DELETE: begin
				if (pos >= 1 && pos <= list_len) begin
					r.removed = list_mem[pos-1];
					for (k = pos - 1; k < list_len - 1; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			oale_pkg::CMD_LOCATE: begin
				for (k = 0; k < list_len; k++) begin
					if (!r.ok && list_mem[k] == v) begin
						r.ok = 1'b1;
						r.found = oale_pkg::POS_W'(k + 1);
					end
				end
			end
			default: ;
		endcase
		r.count = oale_pkg::CNT_W'(list_len);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic queue_cmd(logic [oale_pkg::CMD_W-1:0] c, int p,
			logic [oale_pkg::VAL_W-1:0] v, bit hold);
		list_cmd_t item;
		item.cmd = c;
		item.position = oale_pkg::POS_W'(p);
		item.value = v;
		item.hold = hold;
		cmd_queue.push_back(item);
		queued_items++;
		if (c == oale_pkg::CMD_INSERT && p >= 1 && p <= plan_len + 1 && plan_len < CAPACITY) begin
			plan_len++;
			value_pool.push_back(v);
			if (value_pool.size() > CAPACITY)
				void'(value_pool.pop_front());
		end else if (c == oale_pkg::CMD_DELETE && p >= 1 && p <= plan_len) begin
			plan_len--;
		end
	endtask

	function automatic logic [oale_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return oale_pkg::VAL_W'($urandom_range(0, 7));
			4, 5: begin
				if (value_pool.size() != 0)
					return value_pool[$urandom_range(0, value_pool.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_insert_pos();
		if ($urandom_range(0, 99) < 85 && plan_len < CAPACITY)
			return $urandom_range(1, plan_len + 1);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return (plan_len + 2 <= 65) ? $urandom_range(plan_len + 2, 65) : 65;
			default: return $urandom_range(64, 65);
		endcase
	endfunction

	function automatic int pick_delete_pos();
		if ($urandom_range(0, 99) < 85 && plan_len > 0)
			return $urandom_range(1, plan_len);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return (plan_len + 1 <= 65) ? $urandom_range(plan_len + 1, 65) : 65;
			default: return $urandom_range(64, 65);
		endcase
	endfunction

	task automatic queue_random_cmd();
		int r;
		int ins_pct;
		r = $urandom_range(0, 99);
		ins_pct = (plan_len < 16) ? 50 : 35;
		if (r < ins_pct)
			queue_cmd(oale_pkg::CMD_INSERT, pick_insert_pos(), pick_value(),
				$urandom_range(0, 99) == 0);
		else if (r < 70)
			queue_cmd(oale_pkg::CMD_DELETE, pick_delete_pos(), pick_value(), 1'b0);
		else if (r < 95)
			queue_cmd(oale_pkg::CMD_LOCATE, $urandom_range(0, 65), pick_value(), 1'b0);
		else
			queue_cmd(CMD_UNUSED, $urandom_range(0, 65), pick_value(), 1'b0);
	endtask

	task automatic queue_fill_and_drain();
		queue_cmd(oale_pkg::CMD_LOCATE, 0, pick_value(), 1'b1);
		while (plan_len < CAPACITY)
			queue_cmd(oale_pkg::CMD_INSERT, $urandom_range(1, plan_len + 1), pick_value(), 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 65, pick_value(), 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, $urandom_range(1, CAPACITY), pick_value(), 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 1, pick_value(), 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 64, $urandom, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 65, 0, 1'b0);
		while (plan_len > 0) begin
			if ($urandom_range(0, 7) == 0)
				queue_cmd(oale_pkg::CMD_LOCATE, $urandom_range(0, 65), pick_value(), 1'b0);
			queue_cmd(oale_pkg::CMD_DELETE, $urandom_range(1, plan_len), $urandom, 1'b0);
		end
		queue_cmd(oale_pkg::CMD_DELETE, 1, 0, 1'b0);
	endtask

	initial begin
		queue_cmd(oale_pkg::CMD_LOCATE, 0, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 1, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 0, 32'd5, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 2, 32'd5, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 1, 32'h7fff_ffff, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 2, 32'h8000_0000, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 1, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 2, 32'hffff_ffff, 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 0, 32'h8000_0000, 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 0, 32'd12345, 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 65, 32'hffff_ffff, 1'b0);
		queue_cmd(CMD_UNUSED, 1, 32'd7, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 0, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 5, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 2, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 3, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_DELETE, 1, 32'd0, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 65, 32'd9, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 1, 32'd42, 1'b0);
		queue_cmd(oale_pkg::CMD_INSERT, 3, 32'd42, 1'b0);
		queue_cmd(oale_pkg::CMD_LOCATE, 127, 32'd42, 1'b1);
		queue_cmd(oale_pkg::CMD_DELETE, 127, 32'd0, 1'b0);

		queue_fill_and_drain();
		while (queued_items < 420)
			queue_random_cmd();
		queue_fill_and_drain();
		while (queued_items < 600)
			queue_random_cmd();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// command side: bursts separated by random gaps, hold on items flagged to wait for idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_to_list(s_tuser,
					s_tdata[oale_pkg::POS_W-1:0],
					s_tdata[oale_pkg::POS_W +: oale_pkg::VAL_W]));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0 && (!cmd_queue[0].hold ||
						(!s_tvalid && expected_results.size() == 0))) begin
					next_cmd = cmd_queue.pop_front();
					s_tdata <= oale_pkg::S_TDATA_W'({next_cmd.value, next_cmd.position});
					s_tuser <= next_cmd.cmd;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: check each accepted word, stall on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			stall_run <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_word.ok = m_tuser[0];
				got_word.removed = m_tdata[oale_pkg::VAL_W-1:0];
				got_word.found = m_tdata[oale_pkg::VAL_W +: oale_pkg::POS_W];
				got_word.count = m_tdata[oale_pkg::VAL_W+oale_pkg::POS_W +: oale_pkg::CNT_W];
				if (expected_results.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want_word = expected_results.pop_front();
					if (got_word.ok !== want_word.ok)
						report_mismatch($sformatf("ok got %b want %b",
							got_word.ok, want_word.ok));
					if (got_word.removed !== want_word.removed)
						report_mismatch($sformatf("removed_value got %h want %h",
							got_word.removed, want_word.removed));
					if (got_word.found !== want_word.found)
						report_mismatch($sformatf("found_position got %0d want %0d",
							got_word.found, want_word.found));
					if (got_word.count !== want_word.count)
						report_mismatch($sformatf("count got %0d want %0d",
							got_word.count, want_word.count));
				end
			end
			if (stall_run == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_run <= $urandom_range(8, 60);
			end else begin
				stall_run <= stall_run - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
